// ===== rtl/maze_flood_fill_distance_defines.svh =====
// Assertion macros shared by the RTL
`ifndef MAZE_FLOOD_FILL_DISTANCE_DEFINES_SVH
`define MAZE_FLOOD_FILL_DISTANCE_DEFINES_SVH

// Same-cycle implication
`define MFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mfd check failed");

// Next-cycle implication
`define MFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mfd check failed");

`endif

// ===== rtl/mfd_pkg.sv =====
package mfd_pkg;

   // Grid size defaults and the width of size values
   localparam int DEF_MAX_ROWS = 16;
   localparam int DEF_MAX_COLS = 16;
   localparam int DIM_W        = 7;

   // Register reset values and indexes
   localparam logic [4:0] ROWS_RESET = 5'd4;
   localparam logic [4:0] COLS_RESET = 5'd6;
   localparam logic       CSR_ROWS   = 1'b0;
   localparam logic       CSR_COLS   = 1'b1;

   // Item codes
   localparam logic [1:0] FUNC_WALL  = 2'd0;
   localparam logic [1:0] FUNC_FLOOD = 2'd1;
   localparam logic [1:0] FUNC_READ  = 2'd2;
   localparam logic [1:0] FUNC_UNDEF = 2'd3;

   // Wall sides
   localparam logic [1:0] SIDE_DOWN  = 2'd0;
   localparam logic [1:0] SIDE_UP    = 2'd1;
   localparam logic [1:0] SIDE_RIGHT = 2'd2;
   localparam logic [1:0] SIDE_LEFT  = 2'd3;

   typedef enum logic {
      ST_IDLE,
      ST_FLOOD
   } state_type;

   typedef struct packed {
      logic [1:0] func;
      logic [3:0] cell_row;
      logic [3:0] cell_col;
      logic [1:0] wall_side;
   } req_type;

   typedef struct packed {
      logic [7:0] distance;
      logic       reached;
      logic       bad_cell;
   } rsp_type;

   // Broadcast to every cell
   typedef struct packed {
      logic       start;
      logic       step_en;
      logic [7:0] step;
   } cell_ctl_type;

endpackage

// ===== rtl/mfd_cell.sv =====
module mfd_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  mfd_pkg::cell_ctl_type ctl,
   input  logic                 in_use,
   input  logic                 goal,
   input  logic [3:0]           wall_set,
   input  logic [3:0]           nbr_front,
   output logic                 front,
   output logic                 reached,
   output logic [7:0]           dist_out
);

   logic [3:0] walls_ff, walls_in;
   logic       reached_ff, reached_in;
   logic       front_ff, front_in;
   logic [7:0] dist_ff, dist_in;
   logic       hit;

   // An unreached cell in use is hit when an open side faces a neighbour on the wavefront
   assign hit = in_use && !reached_ff && (|(nbr_front & ~walls_ff));

   always_comb begin
      walls_in   = walls_ff | wall_set;
      reached_in = reached_ff;
      front_in   = front_ff;
      dist_in    = dist_ff;
      if (ctl.start) begin
         front_in = goal;
         if (in_use) begin
            reached_in = goal;
         end
         if (goal) begin
            dist_in = '0;
         end
      end else if (ctl.step_en) begin
         front_in = hit;
         if (hit) begin
            reached_in = 1'b1;
            dist_in    = ctl.step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         walls_ff   <= '0;
         reached_ff <= 1'b0;
         front_ff   <= 1'b0;
      end else begin
         walls_ff   <= walls_in;
         reached_ff <= reached_in;
         front_ff   <= front_in;
      end
   end

   // distance is only reported for reached cells
   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
   end

   assign front    = front_ff;
   assign reached  = reached_ff;
   assign dist_out = dist_ff;

endmodule

// ===== rtl/maze_flood_fill_distance.sv =====
// Channel | Direction | Handshake           | Payload
// req     | in        | req_valid/req_ready | req_data  (func, cell_row, cell_col, wall_side)
// rsp     | out       | rsp_valid/rsp_ready | rsp_data  (distance, reached, bad_cell)
// csr     | in        | csr_write_en        | csr_index, csr_wdata
//
// Wall, read, undefined and bad-goal flood items do not enter the flood state; their result is registered.
// A flood runs through these steps in order: start, the wavefront steps out from the goal,
// a last step that reaches no new cell, then the result register.
// Reset opens all walls and clears all reached marks at once.
// A waiting result does not stop the next transfer in while the slot is freed.
`include "maze_flood_fill_distance_defines.svh"

module maze_flood_fill_distance #(
   parameter int MAX_ROWS = mfd_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLS = mfd_pkg::DEF_MAX_COLS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mfd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mfd_pkg::rsp_type rsp_data,
   input  logic             csr_write_en,
   input  logic             csr_index,
   input  logic [4:0]       csr_wdata
);

   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int IDX_W = $clog2(CELLS);
   localparam int DW    = mfd_pkg::DIM_W;

   mfd_pkg::state_type    state_ff, state_in;
   logic [4:0]            rows_ff, cols_ff;
   logic [7:0]            step_ff, step_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   mfd_pkg::rsp_type      rsp_ff, rsp_in;
   mfd_pkg::cell_ctl_type ctl;

   logic [DW-1:0]    rows_eff, cols_eff, row_w, col_w;
   logic             good, accept, any_front, wall_en;
   logic [IDX_W-1:0] idx, nbr_idx;
   logic [3:0]       mine, theirs;
   logic             nbr_ok;

   logic [CELLS-1:0] front_vec, reached_vec;
   logic [7:0]       dist_arr [CELLS];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= mfd_pkg::ROWS_RESET;
         cols_ff <= mfd_pkg::COLS_RESET;
      end else if (csr_write_en) begin
         if (csr_index == mfd_pkg::CSR_ROWS) begin
            rows_ff <= csr_wdata;
         end else begin
            cols_ff <= csr_wdata;
         end
      end
   end

   // Effective grid size, clamped to 1..MAX
   always_comb begin
      rows_eff = {{(DW-5){1'b0}}, rows_ff};
      cols_eff = {{(DW-5){1'b0}}, cols_ff};
      if (rows_ff == '0) rows_eff = DW'(1);
      else if (rows_eff > DW'(MAX_ROWS)) rows_eff = DW'(MAX_ROWS);
      if (cols_ff == '0) cols_eff = DW'(1);
      else if (cols_eff > DW'(MAX_COLS)) cols_eff = DW'(MAX_COLS);
   end

   assign row_w = DW'(req_data.cell_row);
   assign col_w = DW'(req_data.cell_col);
   assign good  = (row_w < rows_eff) && (col_w < cols_eff);
   assign idx   = IDX_W'(32'(req_data.cell_row) * 32'(MAX_COLS) + 32'(req_data.cell_col));

   assign req_ready = (state_ff == mfd_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign any_front = |front_vec;

   // Wall target: this cell and its neighbour on the chosen side
   always_comb begin
      nbr_ok  = 1'b0;
      nbr_idx = idx;
      mine    = 4'b0001;
      theirs  = 4'b0010;
      unique case (req_data.wall_side)
         mfd_pkg::SIDE_DOWN: begin
            nbr_ok  = (row_w + DW'(1)) < rows_eff;
            nbr_idx = idx + IDX_W'(MAX_COLS);
            mine    = 4'b0001;
            theirs  = 4'b0010;
         end
         mfd_pkg::SIDE_UP: begin
            nbr_ok  = row_w != '0;
            nbr_idx = idx - IDX_W'(MAX_COLS);
            mine    = 4'b0010;
            theirs  = 4'b0001;
         end
         mfd_pkg::SIDE_RIGHT: begin
            nbr_ok  = (col_w + DW'(1)) < cols_eff;
            nbr_idx = idx + IDX_W'(1);
            mine    = 4'b0100;
            theirs  = 4'b1000;
         end
         mfd_pkg::SIDE_LEFT: begin
            nbr_ok  = col_w != '0;
            nbr_idx = idx - IDX_W'(1);
            mine    = 4'b1000;
            theirs  = 4'b0100;
         end
         default: begin
            nbr_ok = 1'b0;
         end
      endcase
   end

   assign wall_en = accept && (req_data.func == mfd_pkg::FUNC_WALL) && good && nbr_ok;

   // Cell broadcast
   always_comb begin
      ctl.start   = accept && (req_data.func == mfd_pkg::FUNC_FLOOD);
      ctl.step_en = (state_ff == mfd_pkg::ST_FLOOD) && any_front;
      ctl.step    = step_ff;
   end

   // Grid of cells, each wired to its four neighbours' wavefront bits
   for (genvar gr = 0; gr < MAX_ROWS; gr++) begin : g_row
      for (genvar gc = 0; gc < MAX_COLS; gc++) begin : g_col
         localparam int I = gr * MAX_COLS + gc;
         logic [3:0] nbr;
         logic [3:0] wset;
         logic       in_use_c;

         assign nbr[0] = (gr + 1 < MAX_ROWS) ? front_vec[(gr + 1 < MAX_ROWS) ? I + MAX_COLS : I]
                                             : 1'b0;
         assign nbr[1] = (gr > 0) ? front_vec[(gr > 0) ? I - MAX_COLS : I] : 1'b0;
         assign nbr[2] = (gc + 1 < MAX_COLS) ? front_vec[(gc + 1 < MAX_COLS) ? I + 1 : I] : 1'b0;
         assign nbr[3] = (gc > 0) ? front_vec[(gc > 0) ? I - 1 : I] : 1'b0;

         assign in_use_c = (DW'(gr) < rows_eff) && (DW'(gc) < cols_eff);
         assign wset = ((wall_en && idx == IDX_W'(I)) ? mine : 4'b0000)
                     | ((wall_en && nbr_idx == IDX_W'(I)) ? theirs : 4'b0000);

         mfd_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctl       (ctl),
            .in_use    (in_use_c),
            .goal      (good && idx == IDX_W'(I)),
            .wall_set  (wset),
            .nbr_front (nbr),
            .front     (front_vec[I]),
            .reached   (reached_vec[I]),
            .dist_out  (dist_arr[I])
         );
      end
   end

   // Sequencer and result register
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         mfd_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_in.distance = '0;
               rsp_in.reached  = 1'b0;
               rsp_in.bad_cell = (req_data.func != mfd_pkg::FUNC_UNDEF) && !good;
               if (req_data.func == mfd_pkg::FUNC_READ && good && reached_vec[idx]) begin
                  rsp_in.reached  = 1'b1;
                  rsp_in.distance = dist_arr[idx];
               end
               if (req_data.func == mfd_pkg::FUNC_FLOOD && good) begin
                  state_in = mfd_pkg::ST_FLOOD;
                  step_in  = 8'd1;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end
         end
         mfd_pkg::ST_FLOOD: begin
            if (any_front) begin
               step_in = (step_ff == 8'hff) ? 8'hff : step_ff + 8'd1;
            end else begin
               state_in     = mfd_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
            end
         end
         default: begin
            state_in = mfd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mfd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   `MFD_ASSERT_NOW(a_busy_no_req, state_ff == mfd_pkg::ST_FLOOD, !req_ready)
   `MFD_ASSERT_NOW(a_step_nonzero, state_ff == mfd_pkg::ST_FLOOD, step_ff != 8'd0)
   `MFD_ASSERT_NEXT(a_flood_done_rsp, state_ff == mfd_pkg::ST_FLOOD && !any_front, rsp_valid_ff && state_ff == mfd_pkg::ST_IDLE)
   `MFD_ASSERT_NEXT(a_bad_read, accept && req_data.func == mfd_pkg::FUNC_READ && !good, rsp_valid_ff && rsp_ff.bad_cell && !rsp_ff.reached)

endmodule

// ===== tb/sv/tb.sv =====
module tb;

   localparam int NROWS = 16;
   localparam int NCOLS = 16;
   localparam int NCELLS = NROWS * NCOLS;
   localparam int CYCLE_LIMIT = 2000000;

   // Golden grid model and queue of expected responses
   class maze_scoreboard;
      int unsigned       rows_cfg;
      int unsigned       cols_cfg;
      bit [3:0]          walls [NCELLS];
      bit                reached [NCELLS];
      bit [7:0]          dist_map [NCELLS];
      mfd_pkg::rsp_type  pending [$];
      int unsigned       errors;

      function void clear_all();
         rows_cfg = int'(mfd_pkg::ROWS_RESET);
         cols_cfg = int'(mfd_pkg::COLS_RESET);
         for (int i = 0; i < NCELLS; i++) begin
            walls[i] = '0;
            reached[i] = 1'b0;
            dist_map[i] = '0;
         end
         pending.delete();
      endfunction

      function int unsigned eff(int unsigned v, int unsigned mx);
         if (v == 0) return 1;
         if (v > mx) return mx;
         return v;
      endfunction

      // Mark a cell and append it to the wavefront if it is new
      function void mark(int unsigned idx, bit [7:0] d, ref int unsigned q[$]);
         if (reached[idx]) return;
         reached[idx] = 1'b1;
         dist_map[idx] = d;
         q.push_back(idx);
      endfunction

      function void fill(int unsigned gr, int unsigned gc, bit good,
                         int unsigned nr, int unsigned nc);
         int unsigned q[$];
         int unsigned idx, r, c;
         bit [3:0] w;
         bit [7:0] nd;
         for (int rr = 0; rr < nr; rr++)
            for (int cc = 0; cc < nc; cc++)
               reached[rr * NCOLS + cc] = 1'b0;
         if (!good) return;
         mark(gr * NCOLS + gc, 8'd0, q);
         while (q.size() > 0) begin
            idx = q[0];
            q.delete(0);
            w = walls[idx];
            nd = (dist_map[idx] == 8'hff) ? 8'hff : dist_map[idx] + 8'd1;
            r = idx / NCOLS;
            c = idx % NCOLS;
            if (r + 1 < nr && !w[0]) mark(idx + NCOLS, nd, q);
            if (r >= 1 && !w[1]) mark(idx - NCOLS, nd, q);
            if (c + 1 < nc && !w[2]) mark(idx + 1, nd, q);
            if (c >= 1 && !w[3]) mark(idx - 1, nd, q);
         end
      endfunction

      function void note_request(mfd_pkg::req_type rq);
         int unsigned nr, nc, r, c, idx;
         bit good;
         mfd_pkg::rsp_type rs;
         nr = eff(rows_cfg, NROWS);
         nc = eff(cols_cfg, NCOLS);
         r = rq.cell_row;
         c = rq.cell_col;
         idx = r * NCOLS + c;
         good = (r < nr) && (c < nc);
         rs = '0;
         if (rq.func == mfd_pkg::FUNC_WALL) begin
            rs.bad_cell = !good;
            if (good) begin
               case (rq.wall_side)
                  mfd_pkg::SIDE_DOWN: if (r + 1 < nr) begin
                     walls[idx][0] = 1'b1; walls[idx + NCOLS][1] = 1'b1;
                  end
                  mfd_pkg::SIDE_UP: if (r >= 1) begin
                     walls[idx][1] = 1'b1; walls[idx - NCOLS][0] = 1'b1;
                  end
                  mfd_pkg::SIDE_RIGHT: if (c + 1 < nc) begin
                     walls[idx][2] = 1'b1; walls[idx + 1][3] = 1'b1;
                  end
                  default: if (c >= 1) begin
                     walls[idx][3] = 1'b1; walls[idx - 1][2] = 1'b1;
                  end
               endcase
            end
         end else if (rq.func == mfd_pkg::FUNC_FLOOD) begin
            rs.bad_cell = !good;
            fill(r, c, good, nr, nc);
         end else if (rq.func == mfd_pkg::FUNC_READ) begin
            rs.bad_cell = !good;
            if (good && reached[idx]) begin
               rs.reached = 1'b1;
               rs.distance = dist_map[idx];
            end
         end
         pending.push_back(rs);
      endfunction

      task check_response(mfd_pkg::rsp_type got);
         mfd_pkg::rsp_type exp_rs;
         if (pending.size() == 0) begin
            report($sformatf("unexpected response %p", got));
            return;
         end
         exp_rs = pending[0];
         pending.delete(0);
         if (got.distance !== exp_rs.distance)
            report($sformatf("distance %0d, wanted %0d", got.distance, exp_rs.distance));
         if (got.reached !== exp_rs.reached)
            report($sformatf("reached %b, wanted %b", got.reached, exp_rs.reached));
         if (got.bad_cell !== exp_rs.bad_cell)
            report($sformatf("bad_cell %b, wanted %b", got.bad_cell, exp_rs.bad_cell));
      endtask

      task report(string msg);
         errors++;
         $display("MISMATCH: %s", msg);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   mfd_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   mfd_pkg::rsp_type rsp_data;
   logic             csr_write_en = 1'b0;
   logic             csr_index = mfd_pkg::CSR_ROWS;
   logic [4:0]       csr_wdata = '0;

   maze_scoreboard sb;
   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   int  sent = 0;
   int  responses = 0;
   longint cycles = 0;

   maze_flood_fill_distance u_dut (.*);

   always #4 clock = ~clock;

   // Cycle count and timeout
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout");
         $display("simulation failed");
         $finish;
      end
   end

   // Response side: random back-pressure, check on transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            sb.check_response(rsp_data);
            responses++;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Present one request and hold it until the transfer; valid drops only while idling
   task automatic send(bit [1:0] f, bit [3:0] r, bit [3:0] c, bit [1:0] s);
      mfd_pkg::req_type rq;
      rq.func = f; rq.cell_row = r; rq.cell_col = c; rq.wall_side = s;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(posedge clock); while (!req_ready);
      sb.note_request(rq);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending.size() > 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(bit idx, bit [4:0] v);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      if (idx == mfd_pkg::CSR_ROWS) sb.rows_cfg = v;
      else sb.cols_cfg = v;
   endtask

   task automatic set_grid(bit [4:0] nr, bit [4:0] nc);
      drain();
      write_csr(mfd_pkg::CSR_ROWS, nr);
      write_csr(mfd_pkg::CSR_COLS, nc);
      csr_write_en <= 1'b0;
   endtask

   // Mostly walls inside the grid in use, floods and reads; some stray items
   task automatic random_batch(int n);
      int unsigned nr, nc, k;
      bit [1:0] f;
      for (int i = 0; i < n; i++) begin
         nr = sb.eff(sb.rows_cfg, NROWS);
         nc = sb.eff(sb.cols_cfg, NCOLS);
         k = $urandom_range(99);
         f = (k < 45) ? mfd_pkg::FUNC_WALL : (k < 55) ? mfd_pkg::FUNC_FLOOD :
             (k < 95) ? mfd_pkg::FUNC_READ : mfd_pkg::FUNC_UNDEF;
         if ($urandom_range(9) == 0)
            send(f, 4'($urandom_range(15)), 4'($urandom_range(15)), 2'($urandom_range(3)));
         else
            send(f, 4'($urandom_range(nr - 1)), 4'($urandom_range(nc - 1)),
                 2'($urandom_range(3)));
      end
   endtask

   initial begin
      sb = new();
      sb.clear_all();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset grid, reads of unreached cells, edges, bad cells
      send(mfd_pkg::FUNC_READ, 4'd0, 4'd0, mfd_pkg::SIDE_DOWN);
      send(mfd_pkg::FUNC_FLOOD, 4'd0, 4'd0, mfd_pkg::SIDE_DOWN);
      send(mfd_pkg::FUNC_READ, 4'd3, 4'd5, mfd_pkg::SIDE_DOWN);
      send(mfd_pkg::FUNC_READ, 4'd4, 4'd0, mfd_pkg::SIDE_DOWN);
      send(mfd_pkg::FUNC_WALL, 4'd0, 4'd0, mfd_pkg::SIDE_UP);
      send(mfd_pkg::FUNC_WALL, 4'd0, 4'd0, mfd_pkg::SIDE_LEFT);
      send(mfd_pkg::FUNC_WALL, 4'd3, 4'd5, mfd_pkg::SIDE_DOWN);
      send(mfd_pkg::FUNC_WALL, 4'd3, 4'd5, mfd_pkg::SIDE_RIGHT);
      send(mfd_pkg::FUNC_WALL, 4'd0, 4'd0, mfd_pkg::SIDE_RIGHT);
      send(mfd_pkg::FUNC_WALL, 4'd1, 4'd1, mfd_pkg::SIDE_UP);
      send(mfd_pkg::FUNC_WALL, 4'd15, 4'd15, mfd_pkg::SIDE_LEFT);
      send(mfd_pkg::FUNC_FLOOD, 4'd2, 4'd2, mfd_pkg::SIDE_LEFT);
      send(mfd_pkg::FUNC_READ, 4'd0, 4'd1, mfd_pkg::SIDE_LEFT);
      send(mfd_pkg::FUNC_READ, 4'd0, 4'd0, mfd_pkg::SIDE_LEFT);
      send(mfd_pkg::FUNC_FLOOD, 4'd15, 4'd0, mfd_pkg::SIDE_DOWN);
      send(mfd_pkg::FUNC_READ, 4'd0, 4'd0, mfd_pkg::SIDE_DOWN);
      send(mfd_pkg::FUNC_UNDEF, 4'd15, 4'd15, mfd_pkg::SIDE_LEFT);
      send(mfd_pkg::FUNC_UNDEF, 4'd0, 4'd0, mfd_pkg::SIDE_DOWN);
      // Alternating edge walls on the full grid to bend the paths
      set_grid(5'd16, 5'd16);
      for (int r = 0; r < 15; r++)
         send(mfd_pkg::FUNC_WALL, 4'(r), (r % 2) ? 4'd0 : 4'd15, mfd_pkg::SIDE_DOWN);
      send(mfd_pkg::FUNC_FLOOD, 4'd0, 4'd0, mfd_pkg::SIDE_UP);
      send(mfd_pkg::FUNC_READ, 4'd15, 4'd0, mfd_pkg::SIDE_UP);
      send(mfd_pkg::FUNC_READ, 4'd15, 4'd15, mfd_pkg::SIDE_UP);
      send(mfd_pkg::FUNC_READ, 4'd8, 4'd7, mfd_pkg::SIDE_UP);

      // Random phases across grid sizes and idling profiles
      send_idle_pct = 10; recv_idle_pct = 57;
      set_grid(5'd0, 5'd31);   random_batch(60);
      set_grid(5'd1, 5'd1);    random_batch(40);
      send_idle_pct = 57; recv_idle_pct = 10;
      set_grid(5'd16, 5'd16);  random_batch(80);
      set_grid(5'd31, 5'd0);   random_batch(60);
      drain();           // sender holds off until all responses are in
      set_grid(5'd5, 5'd9);    random_batch(80);
      send_idle_pct = 0; recv_idle_pct = 0;
      set_grid(5'd16, 5'd2);   random_batch(80);
      set_grid(5'd3, 5'd16);   random_batch(80);
      set_grid(5'd8, 5'd8);    random_batch(80);

      drain();
      $display("covered %0d requests and %0d responses over several grid sizes,", sent,
               responses);
      $display("including walls at edges, bad cells, bent paths and undefined items");
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule
